// ===== hw/rtl/reassembly_slot_table_defines.svh =====
// Assertion helpers for the reassembly slot table.
`ifndef REASSEMBLY_SLOT_TABLE_DEFINES_SVH
`define REASSEMBLY_SLOT_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RSLTAB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rsltab assertion failed");

// Next-cycle implication, disabled while in reset.
`define RSLTAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rsltab assertion failed");

`endif

// ===== hw/rtl/rsltab_pkg.sv =====
package rsltab_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int SEQ_W    = 16;
	localparam int SIZE_W   = 16;
	localparam int FRAGS_W  = 8;
	localparam int TIME_W   = 32;
	localparam int SIU_W    = 5;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;

	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	localparam logic [TIME_W-1:0] RX_TIMEOUT_RST   = 32'd1000;
	localparam logic [SIU_W-1:0]  SLOTS_IN_USE_RST = 5'd16;

	localparam logic REG_RX_TIMEOUT   = 1'b0;
	localparam logic REG_SLOTS_IN_USE = 1'b1;

	localparam logic REQ_GET  = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_MATCHED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_CLAIMED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd2;

	typedef struct packed {
		logic [SEQ_W-1:0]   seq_id;
		logic [SIZE_W-1:0]  total_size;
		logic [FRAGS_W-1:0] frag_count;
		logic [TIME_W-1:0]  start_time;
	} slot_entry_t;

	localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// ===== hw/rtl/rsltab_if.sv =====
interface rsltab_req_if import rsltab_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [SEQ_W-1:0]   seq_id;
	logic [SIZE_W-1:0]  total_size;
	logic [FRAGS_W-1:0] frag_count;

	modport source (output valid, req_type, seq_id, total_size, frag_count, input ready);
	modport sink (input valid, req_type, seq_id, total_size, frag_count, output ready);
endinterface

interface rsltab_rsp_if import rsltab_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;

	modport source (output valid, status, slot_index, input ready);
	modport sink (input valid, status, slot_index, output ready);
endinterface

// ===== hw/rtl/rsltab_ram.sv =====
module rsltab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/reassembly_slot_table.sv =====
// Reassembly slot table.
// req channel: one transaction per request. req_type selects a get (key =
//   seq_id, total_size, frag_count) or a one millisecond tick.
// rsp channel: one transaction per get (status, slot_index); ticks give none.
// APB port: register 0 rx_timeout at 0x0, register 1 slots_in_use at 0x4.
// A tick advances the clock. A get walks the n active slots through the
// slot RAM, one read per cycle: expired slots are freed and the lowest live
// match and lowest free slot are noted in the same pass. A claim is written
// back in the commit cycle. The scan length is set by the single RAM read
// port. With zero slots in use a get skips the scan and goes straight to
// the done state to commit its answer.
// The response sits in an output register; requests keep being accepted
// while it waits, but a get cannot commit until the previous response is
// taken, so a stalled receiver holds the table in its commit cycle.
// Reset frees all slots, zeroes the clock and restores the register
// defaults; slot RAM contents are not cleared and need no clearing pass.
`include "reassembly_slot_table_defines.svh"

module reassembly_slot_table import rsltab_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rsltab_req_if.sink        req,
	rsltab_rsp_if.source      rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (CNT_W > SIU_W) ? CNT_W : SIU_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [TIME_W-1:0]   timeout_q;
	logic [SIU_W-1:0]    siu_q;
	logic [TIME_W-1:0]   now_q;
	logic                busy_q [SLOTS];
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    ptr_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [SEQ_W-1:0]    key_seq_q;
	logic [SIZE_W-1:0]   key_size_q;
	logic [FRAGS_W-1:0]  key_frags_q;
	logic                fnd_match_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic                fnd_free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                out_vld_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [SLOT_W-1:0]   out_slot_q;

	logic                cfg_wr;
	logic [CMP_W-1:0]    siu_ext;
	logic [CNT_W-1:0]    n_sel;
	logic                acc;
	logic                issue;
	logic                ram_we;
	slot_entry_t         ram_wdata;
	slot_entry_t         ram_rdata;
	logic                ent_busy;
	logic                ent_expired;
	logic                ent_live;
	logic                ent_hit;
	logic                last_eval;
	logic                commit;
	logic [IDX_W-1:0]    res_idx;
	logic [IDX_W+SLOT_W-1:0] res_idx_ext;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_RX_TIMEOUT:   prdata = timeout_q;
			REG_SLOTS_IN_USE: prdata = APB_DW'(siu_q);
			default:          prdata = '0;
		endcase
	end

	assign siu_ext = CMP_W'(siu_q);
	assign n_sel   = (siu_ext > CMP_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(siu_ext);

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;

	assign issue = (state_q == ST_SCAN) && (ptr_q < n_q);

	assign ent_busy    = busy_q[rd_idx_s1];
	assign ent_expired = ent_busy && ((now_q - ram_rdata.start_time) >= timeout_q);
	assign ent_live    = ent_busy && !ent_expired;
	assign ent_hit     = ent_live && (ram_rdata.seq_id == key_seq_q)
		&& (ram_rdata.total_size == key_size_q) && (ram_rdata.frag_count == key_frags_q);
	assign last_eval   = rd_vld_s1 && (CNT_W'(rd_idx_s1) == (n_q - CNT_W'(1)));

	assign commit = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);
	assign ram_we = commit && !fnd_match_q && fnd_free_q;

	assign ram_wdata.seq_id     = key_seq_q;
	assign ram_wdata.total_size = key_size_q;
	assign ram_wdata.frag_count = key_frags_q;
	assign ram_wdata.start_time = now_q;

	assign res_idx     = fnd_match_q ? match_idx_q : free_idx_q;
	assign res_idx_ext = {{SLOT_W{1'b0}}, res_idx};

	rsltab_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx_q),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(ptr_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= RX_TIMEOUT_RST;
			siu_q     <= SLOTS_IN_USE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RX_TIMEOUT:   timeout_q <= pwdata;
				REG_SLOTS_IN_USE: siu_q <= pwdata[SIU_W-1:0];
				default:          timeout_q <= timeout_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			key_seq_q   <= req.seq_id;
			key_size_q  <= req.total_size;
			key_frags_q <= req.frag_count;
		end
		if (issue) begin
			rd_idx_s1 <= ptr_q[IDX_W-1:0];
		end
		if (rd_vld_s1 && ent_hit && !fnd_match_q) begin
			match_idx_q <= rd_idx_s1;
		end
		if (rd_vld_s1 && !ent_live && !fnd_free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (commit) begin
			out_status_q <= fnd_match_q ? STATUS_MATCHED
				: (fnd_free_q ? STATUS_CLAIMED : STATUS_NONE);
			out_slot_q   <= (fnd_match_q || fnd_free_q) ? res_idx_ext[SLOT_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			n_q         <= '0;
			ptr_q       <= '0;
			rd_vld_s1   <= 1'b0;
			fnd_match_q <= 1'b0;
			fnd_free_q  <= 1'b0;
			out_vld_q   <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				busy_q[i] <= 1'b0;
			end
		end else begin
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			rd_vld_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (req.req_type == REQ_TICK) begin
							now_q <= now_q + TIME_W'(1);
						end else begin
							n_q         <= n_sel;
							ptr_q       <= '0;
							fnd_match_q <= 1'b0;
							fnd_free_q  <= 1'b0;
							state_q     <= (n_sel == '0) ? ST_DONE : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1) begin
						if (ent_expired) begin
							busy_q[rd_idx_s1] <= 1'b0;
						end
						if (ent_hit) begin
							fnd_match_q <= 1'b1;
						end
						if (!ent_live) begin
							fnd_free_q <= 1'b1;
						end
					end
					if (last_eval) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (ram_we) begin
							busy_q[free_idx_q] <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.status     = out_status_q;
	assign rsp.slot_index = out_slot_q;

	`RSLTAB_ASSERT_IMPL(a_scan_in_range, clk, arst_n, rd_vld_s1, CNT_W'(rd_idx_s1) < n_q)
	`RSLTAB_ASSERT_IMPL(a_free_in_range, clk, arst_n, ram_we, CNT_W'(free_idx_q) < n_q)
	`RSLTAB_ASSERT_NEXT(a_claim_sets_busy, clk, arst_n, ram_we, busy_q[$past(free_idx_q)])
	`RSLTAB_ASSERT_IMPL(a_none_slot_zero, clk, arst_n,
		out_vld_q && (out_status_q == STATUS_NONE), out_slot_q == '0)
	`RSLTAB_ASSERT_IMPL(a_no_read_idle, clk, arst_n, state_q == ST_IDLE, !issue && !rd_vld_s1)

endmodule
